FILE: rtl/core/dwd_pkg.sv
// shared types, constants and config derivation for the daily window dimmer
`timescale 1ns / 1ps
package dwd_pkg;

  // time constants: day length in seconds, start and duration limits in minutes; percent limits
  localparam logic [16:0] DAY_SEC    = 17'd86400;
  localparam logic [10:0] START_MAX  = 11'd1439;
  localparam logic [10:0] DUR_MAX    = 11'd1440;
  localparam logic [6:0]  PCT_FULL   = 7'd100;
  localparam logic [6:0]  RAMP_FLOOR = 7'd25;

  // number of quotient bits, one divider cell each
  localparam int unsigned QUOT_BITS = 7;

  // reciprocal for seconds to minutes: floor(x / 60) = (x * MIN_RECIP) >> 24
  localparam logic [18:0] MIN_RECIP = 19'd279621;
  // reciprocal for percent to duty: floor(b * 255 / 100) = (b * PWM_RECIP) >> 16
  localparam logic [17:0] PWM_RECIP = 18'd167117;

  // register indexes on the config port
  typedef enum logic [2:0] {
    REG_START    = 3'd0,
    REG_DURATION = 3'd1,
    REG_SUNRISE  = 3'd2,
    REG_SUNSET   = 3'd3,
    REG_TARGET   = 3'd4,
    REG_TIMER    = 3'd5
  } reg_idx_e;

  // raw register file
  typedef struct packed {
    logic [10:0] start_min;
    logic [10:0] dur_min;
    logic [10:0] rise_min;
    logic [10:0] fall_min;
    logic [6:0]  tgt;
    logic        timer;
  } raw_cfg_t;

  // config in seconds, clamped and ready for the datapath
  typedef struct packed {
    logic [16:0] start_s;
    logic [16:0] dur_s;
    logic [17:0] end_s;
    logic        wrap;
    logic [16:0] wrap_end;
    logic [16:0] rise_s;
    logic [16:0] fall_s;
    logic [6:0]  tgt;
    logic        timer;
  } cfg_t;

  // window stage to setup stage
  typedef struct packed {
    logic        timer;
    logic        on;
    logic        ramp;
    logic [16:0] e;
    logic [16:0] s;
    logic [16:0] mins_sec;
    logic [6:0]  tgt;
  } win_t;

  // record carried along the divider chain
  typedef struct packed {
    logic        timer;
    logic        on;
    logic        ramp;
    logic        up;
    logic [6:0]  tgt;
    logic [11:0] mins;
    logic [22:0] rem;
    logic [22:0] dsh;
    logic [6:0]  q;
  } div_t;

  localparam raw_cfg_t CFG_RESET = '{
    start_min: 11'd480,
    dur_min:   11'd720,
    rise_min:  11'd60,
    fall_min:  11'd60,
    tgt:       7'd50,
    timer:     1'b0
  };

  // clamp the registers and convert minutes to seconds
  function automatic cfg_t cfg_derive(raw_cfg_t r);
    logic [10:0] sm;
    logic [10:0] dm;
    logic [17:0] rs;
    logic [17:0] fs;
    logic [17:0] sum;
    cfg_t        c;
    sm = (r.start_min > START_MAX) ? START_MAX : r.start_min;
    dm = (r.dur_min > DUR_MAX) ? DUR_MAX : r.dur_min;
    c.start_s  = 17'(({6'b0, sm} << 6) - ({6'b0, sm} << 2));
    c.dur_s    = 17'(({6'b0, dm} << 6) - ({6'b0, dm} << 2));
    c.end_s    = {1'b0, c.start_s} + {1'b0, c.dur_s};
    c.wrap     = c.end_s > {1'b0, DAY_SEC};
    c.wrap_end = 17'(c.end_s - {1'b0, DAY_SEC});
    rs  = ({7'b0, r.rise_min} << 6) - ({7'b0, r.rise_min} << 2);
    fs  = ({7'b0, r.fall_min} << 6) - ({7'b0, r.fall_min} << 2);
    sum = rs + fs;
    if (sum > {1'b0, c.dur_s}) begin
      c.rise_s = c.dur_s >> 1;
      c.fall_s = c.dur_s >> 1;
    end else begin
      c.rise_s = 17'(rs);
      c.fall_s = 17'(fs);
    end
    c.tgt   = (r.tgt > PCT_FULL) ? PCT_FULL : r.tgt;
    c.timer = r.timer;
    return c;
  endfunction

endpackage

FILE: rtl/core/dwd_window.sv
// window stage: on/off decision, elapsed and remaining time, ramp choice
`timescale 1ns / 1ps
module dwd_window (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [16:0]   time_i,
  input  dwd_pkg::cfg_t cfg_i,
  output logic          valid_o,
  input  logic          ready_i,
  output dwd_pkg::win_t data_o
);

  logic          v_q;
  dwd_pkg::win_t data_q;
  dwd_pkg::win_t data_d;
  logic [16:0]   now;
  logic [17:0]   now18;
  logic          on;
  logic [16:0]   elapsed;
  logic [16:0]   remaining;
  logic [16:0]   mins_sec;

  // window test, both plain and wrapping past midnight
  always_comb begin
    now       = (time_i > dwd_pkg::DAY_SEC - 17'd1) ? dwd_pkg::DAY_SEC - 17'd1 : time_i;
    now18     = {1'b0, now};
    on        = 1'b0;
    elapsed   = '0;
    remaining = '0;
    mins_sec  = '0;
    if (!cfg_i.wrap) begin
      on        = (now >= cfg_i.start_s) && (now18 < cfg_i.end_s);
      elapsed   = now - cfg_i.start_s;
      remaining = 17'(cfg_i.end_s - now18);
      if (now < cfg_i.start_s) begin
        mins_sec = cfg_i.start_s - now;
      end else if (now18 < cfg_i.end_s) begin
        mins_sec = 17'(cfg_i.end_s - now18);
      end else begin
        mins_sec = 17'({1'b0, dwd_pkg::DAY_SEC} - now18 + {1'b0, cfg_i.start_s});
      end
    end else begin
      if (now >= cfg_i.start_s) begin
        on        = 1'b1;
        elapsed   = now - cfg_i.start_s;
        remaining = 17'({1'b0, dwd_pkg::DAY_SEC} - now18 + {1'b0, cfg_i.wrap_end});
        mins_sec  = 17'(cfg_i.end_s - now18);
      end else if (now < cfg_i.wrap_end) begin
        on        = 1'b1;
        elapsed   = dwd_pkg::DAY_SEC - cfg_i.start_s + now;
        remaining = cfg_i.wrap_end - now;
        mins_sec  = cfg_i.wrap_end - now;
      end else begin
        mins_sec  = cfg_i.start_s - now;
      end
    end
  end

  // ramp selection, sunrise first
  always_comb begin
    data_d.timer    = cfg_i.timer;
    data_d.on       = on & cfg_i.timer;
    data_d.mins_sec = mins_sec;
    data_d.tgt      = cfg_i.tgt;
    data_d.ramp     = 1'b0;
    data_d.e        = '0;
    data_d.s        = '0;
    if ((cfg_i.rise_s != 17'd0) && (elapsed < cfg_i.rise_s)) begin
      data_d.ramp = 1'b1;
      data_d.e    = elapsed;
      data_d.s    = cfg_i.rise_s;
    end else if ((cfg_i.fall_s != 17'd0) && (remaining < cfg_i.fall_s)) begin
      data_d.ramp = 1'b1;
      data_d.e    = remaining;
      data_d.s    = cfg_i.fall_s;
    end
  end

  // stage register
  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/dwd_setup.sv
// setup stage: ramp numerator, aligned divisor and minutes to change
`timescale 1ns / 1ps
module dwd_setup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  dwd_pkg::win_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output dwd_pkg::div_t data_o
);

  logic          v_q;
  dwd_pkg::div_t data_q;
  dwd_pkg::div_t data_d;
  logic          up;
  logic [6:0]    diff;
  logic [23:0]   num;
  logic [35:0]   mins_prod;

  // numerator |target - 25| * e and divisor s << (QUOT_BITS - 1)
  always_comb begin
    up        = data_i.tgt >= dwd_pkg::RAMP_FLOOR;
    diff      = up ? data_i.tgt - dwd_pkg::RAMP_FLOOR : dwd_pkg::RAMP_FLOOR - data_i.tgt;
    num       = 24'(diff) * 24'(data_i.e);
    mins_prod = 36'(data_i.mins_sec) * 36'(dwd_pkg::MIN_RECIP);
    data_d.timer = data_i.timer;
    data_d.on    = data_i.on;
    data_d.ramp  = data_i.ramp;
    data_d.up    = up;
    data_d.tgt   = data_i.tgt;
    data_d.mins  = mins_prod[35:24];
    data_d.rem   = data_i.ramp ? num[22:0] : 23'd0;
    data_d.dsh   = {data_i.s, 6'b0};
    data_d.q     = '0;
  end

  // stage register
  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/dwd_div_cell.sv
// divider cell: one restoring step, one quotient bit, divisor handed on shifted
`timescale 1ns / 1ps
module dwd_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  dwd_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output dwd_pkg::div_t data_o
);

  logic          v_q;
  dwd_pkg::div_t data_q;
  dwd_pkg::div_t data_d;
  logic          fits;

  // trial subtract of the aligned divisor
  always_comb begin
    fits       = data_i.rem >= data_i.dsh;
    data_d     = data_i;
    data_d.rem = fits ? data_i.rem - data_i.dsh : data_i.rem;
    data_d.q   = {data_i.q[5:0], fits};
    data_d.dsh = data_i.dsh >> 1;
  end

  // stage register
  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/dwd_out.sv
// output stage: brightness, pwm duty and result register
`timescale 1ns / 1ps
module dwd_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  dwd_pkg::div_t      data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [6:0]         brightness_o,
  output logic [7:0]         pwm_o,
  output logic               light_on_o,
  output logic signed [11:0] mins_o
);

  logic               v_q;
  logic [6:0]         bright_q;
  logic [7:0]         pwm_q;
  logic               light_q;
  logic [11:0]        mins_q;
  logic [6:0]         bright_d;
  logic [24:0]        pwm_prod;
  logic [11:0]        mins_d;

  // ramp value rounded down: add quotient going up, subtract ceiling going down
  always_comb begin
    if (!data_i.timer) begin
      bright_d = data_i.tgt;
    end else if (!data_i.on) begin
      bright_d = 7'd0;
    end else if (!data_i.ramp) begin
      bright_d = data_i.tgt;
    end else if (data_i.up) begin
      bright_d = dwd_pkg::RAMP_FLOOR + data_i.q;
    end else begin
      bright_d = dwd_pkg::RAMP_FLOOR - data_i.q - {6'b0, |data_i.rem};
    end
    pwm_prod = 25'(bright_d) * 25'(dwd_pkg::PWM_RECIP);
    mins_d   = data_i.timer ? data_i.mins : 12'hFFF;
  end

  // result register
  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bright_q <= bright_d;
      pwm_q    <= pwm_prod[23:16];
      light_q  <= data_i.on;
      mins_q   <= mins_d;
    end
  end

  assign valid_o      = v_q;
  assign brightness_o = bright_q;
  assign pwm_o        = pwm_q;
  assign light_on_o   = light_q;
  assign mins_o       = $signed(mins_q);

endmodule

FILE: rtl/core/daily_window_dimmer_with_ramps_top.sv
// top level of the daily window dimmer: config registers and the stage chain
// stages: window, setup, seven divider cells, result register
//   (the seven-cell divider chain sets the depth)
// throughput: one request per cycle while out_ready_i does not stall it
// config changes reach requests once written to raw_q and derived into cfg_q
// reset: asynchronous, clears all stage valids and loads the default config
`timescale 1ns / 1ps
module daily_window_dimmer_with_ramps_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [16:0]        time_of_day_sec_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [6:0]         brightness_percent_o,
  output logic [7:0]         pwm_duty_o,
  output logic               light_on_o,
  output logic signed [11:0] minutes_to_change_o
);

  localparam int unsigned NCells = dwd_pkg::QUOT_BITS;

  dwd_pkg::raw_cfg_t raw_q;
  dwd_pkg::cfg_t     cfg_q;
  dwd_pkg::win_t     win_data;
  logic              win_valid;
  logic              win_ready;
  dwd_pkg::div_t     cell_data  [0:NCells];
  logic              cell_valid [0:NCells];
  logic              cell_ready [0:NCells];

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= dwd_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (dwd_pkg::reg_idx_e'(cfg_idx_i))
        dwd_pkg::REG_START:    raw_q.start_min <= cfg_wdata_i;
        dwd_pkg::REG_DURATION: raw_q.dur_min   <= cfg_wdata_i;
        dwd_pkg::REG_SUNRISE:  raw_q.rise_min  <= cfg_wdata_i;
        dwd_pkg::REG_SUNSET:   raw_q.fall_min  <= cfg_wdata_i;
        dwd_pkg::REG_TARGET:   raw_q.tgt       <= cfg_wdata_i[6:0];
        dwd_pkg::REG_TIMER:    raw_q.timer     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // derived config in seconds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dwd_pkg::cfg_derive(dwd_pkg::CFG_RESET);
    end else begin
      cfg_q <= dwd_pkg::cfg_derive(raw_q);
    end
  end

  // window stage
  dwd_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .time_i  (time_of_day_sec_i),
    .cfg_i   (cfg_q),
    .valid_o (win_valid),
    .ready_i (win_ready),
    .data_o  (win_data)
  );

  // setup stage
  dwd_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (win_valid),
    .ready_o (win_ready),
    .data_i  (win_data),
    .valid_o (cell_valid[0]),
    .ready_i (cell_ready[0]),
    .data_o  (cell_data[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < NCells; k++) begin : g_cell
    dwd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[k]),
      .ready_o (cell_ready[k]),
      .data_i  (cell_data[k]),
      .valid_o (cell_valid[k+1]),
      .ready_i (cell_ready[k+1]),
      .data_o  (cell_data[k+1])
    );
  end

  // result stage
  dwd_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (cell_valid[NCells]),
    .ready_o      (cell_ready[NCells]),
    .data_i       (cell_data[NCells]),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .brightness_o (brightness_percent_o),
    .pwm_o        (pwm_duty_o),
    .light_on_o   (light_on_o),
    .mins_o       (minutes_to_change_o)
  );

endmodule

FILE: rtl/core/dwd_checker.sv
// port checker for the daily window dimmer, bound to the top level
`timescale 1ns / 1ps
module dwd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [6:0]         brightness_percent_o,
  input logic [7:0]         pwm_duty_o,
  input logic               light_on_o,
  input logic signed [11:0] minutes_to_change_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(brightness_percent_o)
      && $stable(pwm_duty_o) && $stable(minutes_to_change_o))
    else $error("result changed while stalled");

  // brightness in range and duty zero exactly when dark
  a_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (brightness_percent_o <= 7'd100)
      && ((brightness_percent_o == 7'd0) == (pwm_duty_o == 8'd0)))
    else $error("brightness or duty out of line");

  // full brightness gives full duty
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brightness_percent_o == 7'd100 |-> pwm_duty_o == 8'd255)
    else $error("full brightness without full duty");

  // timer mode outside the window is dark
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !light_on_o && minutes_to_change_o != -12'sd1
      |-> brightness_percent_o == 7'd0)
    else $error("light outside window");

  // inside the window the countdown is a real minute count
  a_mins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && light_on_o
      |-> minutes_to_change_o >= 12'sd0 && minutes_to_change_o <= 12'sd1440)
    else $error("bad minutes to change while on");

endmodule

bind daily_window_dimmer_with_ramps_top dwd_checker u_dwd_checker (.*);
